### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect signals named clk and rst_n in the enclosing module.
`define MFW_ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");

`define MFW_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/mfw_pkg.sv
package mfw_pkg;

    localparam int PIX_W  = 8;
    localparam int WIN    = 7;
    localparam int NELEM  = WIN * WIN;
    localparam int NBANK  = 8;
    localparam int BANK_W = 3;
    localparam int CNT_W  = 14;
    localparam int ROW_W  = 12;
    localparam int K_W    = 6;
    localparam int NCELL  = PIX_W;

    localparam logic OP_PIXEL = 1'b0;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN-1:0] column_t;

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic             clear;
        logic             emit;
        logic             colvalid;
        logic             last;
        logic [ROW_W-1:0] row;
    } fetch_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [K_W-1:0]     k;
        logic [NELEM-1:0]   mask;
        pix_t [NELEM-1:0]   vals;
        pix_t               res;
    } rank_bus_t;

endpackage

### hw/rtl/mfw_line_store.sv
module mfw_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [mfw_pkg::BANK_W-1:0]        wbank,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  mfw_pkg::pix_t                     wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output mfw_pkg::pix_t [mfw_pkg::NBANK-1:0] rdata
);
    import mfw_pkg::*;

    logic [NBANK*PIX_W-1:0] mem [DEPTH];
    pix_t [NBANK-1:0]       rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wbank*PIX_W +: PIX_W] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rdata = rd_reg;

endmodule

### hw/rtl/mfw_window.sv
module mfw_window (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  mfw_pkg::fetch_t                    fetch,
    input  mfw_pkg::pix_t [mfw_pkg::NBANK-1:0] rd_data,
    input  logic [2:0]                         n_eff,
    input  logic [2:0]                         half,
    input  logic [mfw_pkg::CNT_W-1:0]          h_eff,
    output mfw_pkg::rank_bus_t                 bus
);
    import mfw_pkg::*;

    column_t            win_reg  [WIN];
    column_t            win_next [WIN];
    column_t            col_new;
    logic [WIN-1:0]     colv_reg;
    logic [WIN-1:0]     colv_next;
    logic [WIN-1:0]     colmask;
    logic [WIN-1:0]     rowmask;
    logic [BANK_W-1:0]  bank_idx [WIN];
    logic [CNT_W-1:0]   rsum [WIN];
    logic [2:0]         ncol;
    logic [2:0]         nrow;
    logic [K_W-1:0]     prod;
    rank_bus_t          bus_next;
    rank_bus_t          bus_reg;

    always_comb
    begin
        for (int a = 0; a < WIN; a++)
        begin
            bank_idx[a] = BANK_W'(fetch.row[BANK_W-1:0] - BANK_W'(half) + BANK_W'(a));
            col_new[a]  = rd_data[bank_idx[a]];
            rsum[a]     = CNT_W'(fetch.row) + CNT_W'(a);
            rowmask[a]  = (3'(a) < n_eff) && (rsum[a] >= CNT_W'(half))
                          && ((rsum[a] - CNT_W'(half)) < h_eff);
        end
        for (int j = 0; j < WIN - 1; j++)
        begin
            win_next[j]  = win_reg[j+1];
            colv_next[j] = !fetch.clear && colv_reg[j+1];
        end
        win_next[WIN-1]  = col_new;
        colv_next[WIN-1] = fetch.colvalid;
        ncol = '0;
        nrow = '0;
        for (int j = 0; j < WIN; j++)
        begin
            colmask[j] = colv_next[j] && (3'(j) >= (3'(WIN) - n_eff));
            ncol       = ncol + 3'(colmask[j]);
            nrow       = nrow + 3'(rowmask[j]);
        end
        prod = K_W'(ncol) * K_W'(nrow);
        bus_next       = '0;
        bus_next.valid = fetch.valid && fetch.emit;
        bus_next.last  = fetch.last;
        bus_next.k     = prod >> 1;
        for (int j = 0; j < WIN; j++)
        begin
            for (int a = 0; a < WIN; a++)
            begin
                bus_next.mask[j*WIN+a] = colmask[j] && rowmask[a];
                bus_next.vals[j*WIN+a] = win_next[j][a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && fetch.valid)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colv_reg <= '0;
            bus_reg  <= '0;
        end
        else if (en)
        begin
            if (fetch.valid)
            begin
                colv_reg <= colv_next;
            end
            bus_reg <= bus_next;
        end
    end

    assign bus = bus_reg;

endmodule

### hw/rtl/mfw_rank_cell.sv
module mfw_rank_cell #(
    parameter int BIT = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  mfw_pkg::rank_bus_t din,
    output mfw_pkg::rank_bus_t dout
);
    import mfw_pkg::*;

    logic [K_W-1:0] cnt0;
    logic           sel;
    rank_bus_t      nxt;
    rank_bus_t      dout_reg;

    always_comb
    begin
        cnt0 = '0;
        for (int e = 0; e < NELEM; e++)
        begin
            cnt0 = cnt0 + K_W'(din.mask[e] && !din.vals[e][BIT]);
        end
        sel = (din.k >= cnt0);
        nxt = din;
        for (int e = 0; e < NELEM; e++)
        begin
            nxt.mask[e] = din.mask[e] && (din.vals[e][BIT] == sel);
        end
        nxt.k        = sel ? (din.k - cnt0) : din.k;
        nxt.res[BIT] = sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (en)
        begin
            dout_reg <= nxt;
        end
    end

    assign dout = dout_reg;

endmodule

### hw/rtl/median_filter_window_core.sv
// Streaming 2D median filter over 8-bit grey pixels in raster order.
// The slave stream carries one transaction per pixel or flush request; the
// master stream returns one median per image position, in raster order, with
// tlast on the last position of the frame. The configuration channel writes
// window size, image width and image height; every write restarts the frame.
// A transaction that makes an output position complete produces its median
// after the column fetch schedule, one line store read, one window stage,
// eight rank cells and the output register. Throughput is one transaction
// per cycle while the output is not stalled, except that the first output
// of each row holds off new transactions while the window columns preload
// through the single read port of the line store. After the last pixel,
// one flush transaction drains one pending output.
// Reset clears all positions and loads window 3, width 1024, height 1024.
// When the receiver stalls, the output register holds its transaction and
// the pipeline keeps accepting until its last rank cell holds a result, then
// tready drops until the receiver takes the waiting transaction.
`include "assert_macros.svh"

module median_filter_window_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] median_out
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import mfw_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int JW = CW + 2;
    localparam int XW = CNT_W;

    logic [2:0]       win_size_reg;
    logic [10:0]      img_w_reg;
    logic [12:0]      img_h_reg;
    logic [CW-1:0]    in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic             in_done_reg;
    logic [CW-1:0]    out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic             job_valid_reg;
    logic [JW-1:0]    job_col_reg;
    logic [1:0]       job_cnt_reg;
    logic             job_clear_reg;
    logic             job_last_reg;
    logic [ROW_W-1:0] job_row_reg;

    logic             en;
    logic             busy;
    logic             acc;
    logic             wr;
    logic             cfg_wr;
    logic [2:0]       n_eff;
    logic [2:0]       half;
    logic [2:0]       lo;
    logic [XW-1:0]    w_eff;
    logic [XW-1:0]    h_eff;
    logic [XW-1:0]    icol_inc;
    logic [XW-1:0]    irow_inc;
    logic [XW-1:0]    out_col_inc;
    logic [XW-1:0]    rr;
    logic [XW-1:0]    cc;
    logic [CW-1:0]    in_col_w;
    logic [ROW_W-1:0] in_row_w;
    logic             done_w;
    logic             ready_out;
    logic             out_last;

    fetch_t           fetch;
    fetch_t           f1_reg;
    pix_t [NBANK-1:0] rd_data;
    rank_bus_t        chain [NCELL+1];

    logic             m_valid_reg;
    pix_t             m_data_reg;
    logic             m_last_reg;

    always_comb
    begin
        n_eff = (win_size_reg == 3'd0) ? 3'd1 : win_size_reg;
        half  = n_eff >> 1;
        lo    = n_eff - 3'd1 - half;
        if (img_w_reg == '0)
        begin
            w_eff = XW'(1);
        end
        else if (XW'(img_w_reg) > XW'(MAX_WIDTH))
        begin
            w_eff = XW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = XW'(img_w_reg);
        end
        h_eff = (img_h_reg == '0) ? XW'(1) : XW'(img_h_reg);

        case (cfg_index)
            REG_WINDOW_SIZE,
            REG_IMAGE_WIDTH,
            REG_IMAGE_HEIGHT: cfg_wr = cfg_valid;
            default:          cfg_wr = 1'b0;
        endcase

        acc      = s_axis_tvalid && s_axis_tready;
        wr       = acc && (s_axis_tuser[0] == OP_PIXEL) && !in_done_reg;
        icol_inc = XW'(in_col_reg) + XW'(1);
        irow_inc = XW'(in_row_reg) + XW'(1);
        in_col_w = in_col_reg;
        in_row_w = in_row_reg;
        done_w   = in_done_reg;
        if (wr)
        begin
            if (icol_inc >= w_eff)
            begin
                in_col_w = '0;
                if (irow_inc >= h_eff)
                begin
                    in_row_w = '0;
                    done_w   = 1'b1;
                end
                else
                begin
                    in_row_w = irow_inc[ROW_W-1:0];
                end
            end
            else
            begin
                in_col_w = icol_inc[CW-1:0];
            end
        end

        rr = XW'(out_row_reg) + XW'(lo);
        if (rr > h_eff - XW'(1))
        begin
            rr = h_eff - XW'(1);
        end
        cc = XW'(out_col_reg) + XW'(lo);
        if (cc > w_eff - XW'(1))
        begin
            cc = w_eff - XW'(1);
        end
        ready_out = acc && (done_w || (XW'(in_row_w) > rr)
                    || ((XW'(in_row_w) == rr) && (XW'(in_col_w) > cc)));
        out_last    = (XW'(out_row_reg) == h_eff - XW'(1))
                      && (XW'(out_col_reg) == w_eff - XW'(1));
        out_col_inc = XW'(out_col_reg) + XW'(1);

        fetch.valid    = job_valid_reg;
        fetch.clear    = job_clear_reg;
        fetch.emit     = (job_cnt_reg == 2'd0);
        fetch.colvalid = (XW'(job_col_reg) < w_eff);
        fetch.last     = job_last_reg;
        fetch.row      = job_row_reg;

        busy          = job_valid_reg && (job_cnt_reg != 2'd0);
        en            = !(chain[NCELL].valid && m_valid_reg && !m_axis_tready);
        s_axis_tready = en && !busy;
        cfg_ready     = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg  <= 3'd3;
            img_w_reg     <= 11'd1024;
            img_h_reg     <= 13'd1024;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_done_reg   <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            job_valid_reg <= 1'b0;
            job_col_reg   <= '0;
            job_cnt_reg   <= '0;
            job_clear_reg <= 1'b0;
            job_last_reg  <= 1'b0;
            job_row_reg   <= '0;
            f1_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_WINDOW_SIZE:  win_size_reg <= cfg_data[2:0];
                    REG_IMAGE_WIDTH:  img_w_reg    <= cfg_data[10:0];
                    REG_IMAGE_HEIGHT: img_h_reg    <= cfg_data;
                    default:          ;
                endcase
            end

            if (cfg_wr || (ready_out && out_last))
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                in_done_reg <= 1'b0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (acc)
            begin
                in_col_reg  <= in_col_w;
                in_row_reg  <= in_row_w;
                in_done_reg <= done_w;
                if (ready_out)
                begin
                    if (out_col_inc >= w_eff)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_inc[CW-1:0];
                    end
                end
            end

            if (en)
            begin
                f1_reg <= fetch;
                if (busy)
                begin
                    job_cnt_reg   <= job_cnt_reg - 2'd1;
                    job_col_reg   <= job_col_reg + JW'(1);
                    job_clear_reg <= 1'b0;
                end
                else
                begin
                    job_valid_reg <= ready_out;
                    job_row_reg   <= out_row_reg;
                    job_last_reg  <= out_last;
                    if (out_col_reg == '0)
                    begin
                        job_col_reg   <= '0;
                        job_cnt_reg   <= lo[1:0];
                        job_clear_reg <= 1'b1;
                    end
                    else
                    begin
                        job_col_reg   <= JW'(out_col_reg) + JW'(lo);
                        job_cnt_reg   <= 2'd0;
                        job_clear_reg <= 1'b0;
                    end
                end
            end
        end
    end

    mfw_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr),
        .wbank (in_row_reg[BANK_W-1:0]),
        .waddr (in_col_reg),
        .wdata (s_axis_tdata),
        .re    (en && job_valid_reg),
        .raddr (job_col_reg[CW-1:0]),
        .rdata (rd_data)
    );

    mfw_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .fetch   (f1_reg),
        .rd_data (rd_data),
        .n_eff   (n_eff),
        .half    (half),
        .h_eff   (h_eff),
        .bus     (chain[0])
    );

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        mfw_rank_cell #(
            .BIT (PIX_W - 1 - g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (!m_valid_reg || m_axis_tready)
        begin
            m_valid_reg <= chain[NCELL].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!m_valid_reg || m_axis_tready)
        begin
            m_data_reg <= chain[NCELL].res;
            m_last_reg <= chain[NCELL].last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    `MFW_ASSERT_IMPLY(a_clear_at_col0, fetch.valid && fetch.clear, job_col_reg == '0)
    `MFW_ASSERT_IMPLY(a_median_found, chain[NCELL].valid, chain[NCELL].mask != '0)
    `MFW_ASSERT_IMPLY(a_out_col_range, 1'b1, XW'(out_col_reg) < w_eff)
    `MFW_ASSERT_NEXT(a_restart_after_last, ready_out && out_last && !cfg_wr, out_row_reg == '0 && out_col_reg == '0 && !in_done_reg)

endmodule
